// ===== hw/rtl/sohp_pkg.sv =====
`timescale 1ns / 1ps

package sohp_pkg;

    localparam int unsigned CfgIdxW = 2;
    localparam int unsigned CfgDataW = 32;
    localparam int unsigned SampleW = 24;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_CUTOFF = 2'd0,
        CFG_SHARP  = 2'd1,
        CFG_PERIOD = 2'd2,
        CFG_NONE   = 2'd3
    } t_cfg_idx;

    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_CLEAR  = 1'b1;

    localparam logic [31:0] RstCutoff = 32'd655360;
    localparam logic [23:0] RstSharp  = 24'd32768;
    localparam logic [31:0] RstPeriod = 32'd4294967;

    typedef struct packed {
        logic               kind;
        logic [SampleW-1:0] sample_in;
    } t_in_item;

    typedef struct packed {
        logic [SampleW-1:0] sample_out;
        logic               saturated;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_COEF,
        ST_MAC,
        ST_SCALE,
        ST_OUT
    } t_state;

    // Bit-serial shift-add multiplier control.
    typedef struct packed {
        logic start;
        logic busy;
    } t_mul_ctl;

endpackage

// ===== hw/rtl/sohp_serial_mul.sv =====
`timescale 1ns / 1ps

// Unsigned shift-add multiplier: one multiplier bit per cycle.
module sohp_serial_mul #(
    parameter int unsigned AW = 64,
    parameter int unsigned BW = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [AW-1:0]    i_a,
    input  logic [BW-1:0]    i_b,
    output logic             o_done,
    output logic [AW+BW-1:0] o_p
);
    localparam int unsigned CW = $clog2(BW + 1);
    logic [AW+BW-1:0] r_acc, n_acc;
    logic [AW+BW-1:0] r_a;
    logic [BW-1:0]    r_b;
    logic [CW-1:0]    r_cnt;
    logic             r_busy;

    always_comb begin
        n_acc = r_acc;
        if (r_b[0]) begin
            n_acc = r_acc + r_a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(BW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc <= '0;
            r_a   <= {{BW{1'b0}}, i_a};
            r_b   <= i_b;
        end else if (r_busy) begin
            r_acc <= n_acc;
            r_a   <= {r_a[AW+BW-2:0], 1'b0};
            r_b   <= {1'b0, r_b[BW-1:1]};
        end
    end

    assign o_p = r_acc;
endmodule

// ===== hw/rtl/sohp_serial_div.sv =====
`timescale 1ns / 1ps

// Restoring divider: one quotient bit per cycle.
module sohp_serial_div #(
    parameter int unsigned NW = 64,
    parameter int unsigned DW = 36
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic          o_done,
    output logic [NW-1:0] o_q
);
    localparam int unsigned CW = $clog2(NW + 1);
    logic [DW:0]   r_rem;
    logic [DW:0]   n_trial;
    logic [DW:0]   n_shift;
    logic [NW-1:0] r_q;
    logic [DW-1:0] r_den;
    logic [CW-1:0] r_cnt;
    logic          r_busy;

    always_comb begin
        n_shift = {r_rem[DW-1:0], r_q[NW-1]};
        n_trial = n_shift - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(NW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_q   <= i_num;
            r_den <= i_den;
        end else if (r_busy) begin
            if (!n_trial[DW]) begin
                r_rem <= n_trial;
                r_q   <= {r_q[NW-2:0], 1'b1};
            end else begin
                r_rem <= n_shift;
                r_q   <= {r_q[NW-2:0], 1'b0};
            end
        end
    end

    assign o_q = r_q;
endmodule

// ===== hw/rtl/second_order_high_pass_iir.sv =====
`timescale 1ns / 1ps

// Second-order high-pass IIR filter, bilinear discretization.
// Input channel (i_in_valid / o_in_stall) carries one item: kind and sample_in.
// A sample item yields one output item on o_out_valid / i_out_stall; a clear
// item zeroes the three past inputs and outputs and yields nothing.
// Three config registers (cutoff, sharpness, period) are written through
// i_cfg_we / i_cfg_idx / i_cfg_data; each write to one of them re-derives
// 2a/Q, a^2 and the inverse denominator on a shared bit-serial multiplier
// and divider. The user must make writes only while the block is idle; the
// block itself does not enforce this. A sample item forms its linear term,
// then two 32-bit bit-serial products against the coefficients and one
// 32-bit scaling product on the shared shift-add multiplier, then output.
// No new item is taken while a sample is in progress; a clear item is
// absorbed in the idle state, which the block does not leave.
// One item is in flight at a time.
// Reset (synchronous, active low) restores default registers, zeroes the
// delays and re-derives coefficients; input is stalled until done.
// The output item is held in a register until the receiver takes it; the
// next input item is not taken while it waits.
module second_order_high_pass_iir (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  sohp_pkg::t_in_item        i_in_item,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output sohp_pkg::t_out_item       o_out_item,
    input  logic                      i_cfg_we,
    input  logic [sohp_pkg::CfgIdxW-1:0]  i_cfg_idx,
    input  logic [sohp_pkg::CfgDataW-1:0] i_cfg_data
);
    localparam int unsigned SW = sohp_pkg::SampleW;
    localparam int unsigned AW = 128;

    sohp_pkg::t_state r_state, n_state;
    logic [31:0] r_cutoff, r_period;
    logic [23:0] r_sharp;
    logic [31:0] r_c1, r_c2, r_inv;
    logic signed [SW-1:0] r_u1, r_u2, r_u3, r_y1, r_y2, r_y3, r_u;
    logic signed [AW-1:0] r_acc;
    logic [3:0]  r_step;
    logic        r_cfg_dirty;
    logic [SW-1:0] r_out;
    logic        r_sat;

    logic          mul_start, mul_done;
    logic [63:0]   mul_a;
    logic [31:0]   mul_b;
    logic [95:0]   mul_p;
    logic          div_start, div_done;
    logic [63:0]   div_num;
    logic [35:0]   div_den;
    logic [63:0]   div_q;

    sohp_serial_mul #(.AW(64), .BW(32)) u_mul (
        .i_clk, .i_rst_n, .i_start(mul_start), .i_a(mul_a), .i_b(mul_b),
        .o_done(mul_done), .o_p(mul_p)
    );
    sohp_serial_div #(.NW(64), .DW(36)) u_div (
        .i_clk, .i_rst_n, .i_start(div_start), .i_num(div_num), .i_den(div_den),
        .o_done(div_done), .o_q(div_q)
    );

    // Working registers for the coefficient and sample sequences.
    logic [63:0] r_a24;
    logic signed [SW+2:0] r_term;
    logic        r_neg_t;
    logic        r_neg;
    logic [AW-1:0] r_mag;
    logic        r_busy_op;

    logic in_acc, out_acc;
    assign out_acc = o_out_valid && !i_out_stall;
    assign o_in_stall = (r_state != sohp_pkg::ST_IDLE) || o_out_valid || r_cfg_dirty;
    assign in_acc = i_in_valid && !o_in_stall;

    function automatic logic signed [SW+2:0] sx(input logic signed [SW-1:0] v);
        return (SW+3)'(v);
    endfunction

    // Combinational intermediates for the ST_COEF, ST_MAC and ST_SCALE steps.
    logic signed [SW+2:0] t_lin;
    logic [63:0] w_sq_r, w_c1_r;
    logic [35:0] w_den;
    logic [AW-1:0] w_prodterm;
    logic [AW-1:0] w_scaled;
    logic [AW-1:0] w_q;
    logic [SW-1:0] w_maxpos;
    logic        w_over;

    always_comb begin
        t_lin = sx(r_u) - sx(r_u1) - sx(r_u2) + sx(r_u3) + sx(r_y1) + sx(r_y2) - sx(r_y3);
        w_sq_r = 64'(mul_p[95:24]) + 64'(mul_p[23]);
        w_c1_r = div_q;
        w_den = 36'(64'd1 << 26) + 36'(r_c1) + 36'(r_c2);
        w_prodterm = AW'(mul_p);
        w_scaled = AW'(mul_p) + (AW'(1) << 55);
        w_q = w_scaled >> 56;
        w_maxpos = {1'b0, {(SW-1){1'b1}}};
        w_over = r_neg ? (w_q > AW'(w_maxpos) + AW'(1)) : (w_q > AW'(w_maxpos));
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sohp_pkg::ST_IDLE: begin
                if (r_cfg_dirty) n_state = sohp_pkg::ST_COEF;
                else if (in_acc && i_in_item.kind == sohp_pkg::KIND_SAMPLE)
                    n_state = sohp_pkg::ST_MAC;
            end
            sohp_pkg::ST_COEF: if (r_step == 4'd5) n_state = sohp_pkg::ST_IDLE;
            sohp_pkg::ST_MAC: if (r_step == 4'd3) n_state = sohp_pkg::ST_SCALE;
            sohp_pkg::ST_SCALE: if (r_step == 4'd2) n_state = sohp_pkg::ST_OUT;
            sohp_pkg::ST_OUT: n_state = sohp_pkg::ST_IDLE;
            default: n_state = sohp_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        mul_start = 1'b0;
        mul_a = '0;
        mul_b = '0;
        div_start = 1'b0;
        div_num = '0;
        div_den = '0;
        unique case (r_state)
            sohp_pkg::ST_COEF: begin
                if (!r_busy_op) begin
                    case (r_step)
                        4'd0: begin
                            mul_start = 1'b1;
                            mul_a = 64'(r_cutoff);
                            mul_b = r_period;
                        end
                        4'd1: begin
                            mul_start = 1'b1;
                            mul_a = r_a24;
                            mul_b = r_a24[31:0];
                        end
                        4'd2: begin
                            div_start = 1'b1;
                            div_num = (r_a24 << 17) + 64'(r_sharp[23:1]);
                            div_den = 36'(r_sharp);
                        end
                        4'd4: begin
                            div_start = 1'b1;
                            div_num = (64'(1) << 56) + 64'(w_den[35:1]);
                            div_den = w_den;
                        end
                        default: ;
                    endcase
                end
            end
            sohp_pkg::ST_MAC: begin
                if (!r_busy_op && (r_step == 4'd1 || r_step == 4'd2)) begin
                    mul_start = 1'b1;
                    mul_a = r_term[SW+2] ? 64'(-r_term) : 64'(r_term);
                    mul_b = (r_step == 4'd1) ? r_c1 : r_c2;
                end
            end
            sohp_pkg::ST_SCALE: begin
                if (!r_busy_op && r_step == 4'd0) begin
                    mul_start = 1'b1;
                    mul_a = r_mag[63:0];
                    mul_b = r_inv;
                end
            end
            default: ;
        endcase
    end

    logic op_done;
    assign op_done = mul_done || div_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sohp_pkg::ST_IDLE;
            r_cutoff <= sohp_pkg::RstCutoff;
            r_sharp <= sohp_pkg::RstSharp;
            r_period <= sohp_pkg::RstPeriod;
            r_cfg_dirty <= 1'b1;
            r_step <= '0;
            r_busy_op <= 1'b0;
            o_out_valid <= 1'b0;
            r_u1 <= '0; r_u2 <= '0; r_u3 <= '0;
            r_y1 <= '0; r_y2 <= '0; r_y3 <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (sohp_pkg::t_cfg_idx'(i_cfg_idx))
                    sohp_pkg::CFG_CUTOFF: begin r_cutoff <= i_cfg_data; r_cfg_dirty <= 1'b1; end
                    sohp_pkg::CFG_SHARP: begin r_sharp <= i_cfg_data[23:0]; r_cfg_dirty <= 1'b1; end
                    sohp_pkg::CFG_PERIOD: begin r_period <= i_cfg_data; r_cfg_dirty <= 1'b1; end
                    default: ;
                endcase
            end
            if (out_acc) o_out_valid <= 1'b0;
            if (mul_start || div_start) r_busy_op <= 1'b1;
            if (op_done) begin
                r_busy_op <= 1'b0;
                r_step <= r_step + 1'b1;
            end
            unique case (r_state)
                sohp_pkg::ST_IDLE: begin
                    r_step <= '0;
                    if (r_cfg_dirty) r_cfg_dirty <= 1'b0;
                    else if (in_acc) begin
                        if (i_in_item.kind == sohp_pkg::KIND_CLEAR) begin
                            r_u1 <= '0; r_u2 <= '0; r_u3 <= '0;
                            r_y1 <= '0; r_y2 <= '0; r_y3 <= '0;
                        end else begin
                            r_u <= i_in_item.sample_in;
                        end
                    end
                end
                sohp_pkg::ST_COEF: begin
                    if (r_step == 4'd3) r_step <= 4'd4;
                    if (r_step == 4'd5) r_step <= '0;
                    if (op_done) begin
                        case (r_step)
                            4'd0: r_a24 <= 64'(mul_p[63:24]) + 64'(mul_p[23]);
                            4'd1: r_c2 <= (r_a24 > 64'hFFFF_FFFF || w_sq_r > 64'hFFFF_FFFF)
                                    ? 32'hFFFF_FFFF : w_sq_r[31:0];
                            4'd2: r_c1 <= (r_sharp == '0 || w_c1_r > 64'hFFFF_FFFF)
                                    ? 32'hFFFF_FFFF : w_c1_r[31:0];
                            4'd4: r_inv <= div_q[31:0];
                            default: ;
                        endcase
                    end
                end
                sohp_pkg::ST_MAC: begin
                    if (r_step == 4'd0) begin
                        r_acc <= AW'(t_lin) <<< 26;
                        r_term <= sx(r_y1) - sx(r_y2) - sx(r_y3);
                        r_neg_t <= 1'b0;
                        r_step <= 4'd1;
                    end
                    if (op_done) begin
                        if (r_term[SW+2]) r_acc <= r_acc + w_prodterm;
                        else r_acc <= r_acc - w_prodterm;
                        r_term <= sx(r_y3) + (SW+3)'(3) * sx(r_y2)
                                  + (SW+3)'(3) * sx(r_y1);
                    end
                    if (r_step == 4'd3) begin
                        r_neg <= r_acc[AW-1];
                        r_mag <= r_acc[AW-1] ? -r_acc : r_acc;
                        r_step <= '0;
                    end
                end
                sohp_pkg::ST_SCALE: begin
                    if (r_step == 4'd2) begin
                        r_step <= '0;
                        r_sat <= w_over || (r_mag[AW-1:64] != '0);
                        if (w_over || r_mag[AW-1:64] != '0)
                            r_out <= r_neg ? {1'b1, {(SW-1){1'b0}}} : w_maxpos;
                        else
                            r_out <= r_neg ? SW'(-w_q) : SW'(w_q);
                    end
                    if (op_done) r_step <= 4'd2;
                end
                sohp_pkg::ST_OUT: begin
                    r_u3 <= r_u2; r_u2 <= r_u1; r_u1 <= r_u;
                    r_y3 <= r_y2; r_y2 <= r_y1; r_y1 <= r_out;
                    o_out_valid <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    assign o_out_item.sample_out = r_out;
    assign o_out_item.saturated = r_sat;
    logic unused;
    assign unused = r_neg_t ^ r_mag[0] ^ w_scaled[0];
endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

    localparam int unsigned IdleCycles = 400;
    localparam int unsigned WatchLimit = 20000;
    localparam longint MaxPos = 64'sd8388607;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          in_valid = 1'b0;
    logic                          in_stall;
    sohp_pkg::t_in_item            in_item = '0;
    logic                          out_valid;
    logic                          out_stall = 1'b0;
    sohp_pkg::t_out_item           out_item;
    logic                          cfg_we = 1'b0;
    logic [sohp_pkg::CfgIdxW-1:0]  cfg_idx = sohp_pkg::CFG_NONE;
    logic [sohp_pkg::CfgDataW-1:0] cfg_data = '0;

    second_order_high_pass_iir u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (in_valid),
        .o_in_stall       (in_stall),
        .i_in_item        (in_item),
        .o_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .o_out_item       (out_item),
        .i_cfg_we         (cfg_we),
        .i_cfg_idx        (cfg_idx),
        .i_cfg_data       (cfg_data)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // filter model state
    logic [31:0] cutoff_reg = sohp_pkg::RstCutoff;
    logic [23:0] sharp_reg  = sohp_pkg::RstSharp;
    logic [31:0] period_reg = sohp_pkg::RstPeriod;
    logic [31:0] coef_2aq, coef_asq, inv_den;
    longint      hist_u [3];
    longint      hist_y [3];

    sohp_pkg::t_out_item expected_outputs [$];
    int          mismatches = 0;
    int          burst_left = 0;
    int          quiet_cycles = 0;

    function automatic void derive_coefs();
        logic [63:0] prod, a24, sq, c1, c2, num, den;
        prod = 64'(cutoff_reg) * 64'(period_reg);
        a24 = (prod >> 24) + ((prod >> 23) & 64'd1);
        if (a24 > 64'hFFFF_FFFF) begin
            c2 = 64'hFFFF_FFFF;
        end else begin
            sq = a24 * a24;
            c2 = (sq >> 24) + ((sq >> 23) & 64'd1);
            if (c2 > 64'hFFFF_FFFF) c2 = 64'hFFFF_FFFF;
        end
        if (sharp_reg == 24'd0) begin
            c1 = 64'hFFFF_FFFF;
        end else begin
            num = a24 << 17;
            c1 = (num + {40'd0, sharp_reg} / 2) / {40'd0, sharp_reg};
            if (c1 > 64'hFFFF_FFFF) c1 = 64'hFFFF_FFFF;
        end
        coef_2aq = c1[31:0];
        coef_asq = c2[31:0];
        den = (64'd4 << 24) + c1 + c2;
        inv_den = 32'(((64'd1 << 56) + den / 2) / den);
    endfunction

    function automatic void clear_history();
        for (int i = 0; i < 3; i++) begin
            hist_u[i] = 0;
            hist_y[i] = 0;
        end
    endfunction

    function automatic bit filter_step(input sohp_pkg::t_in_item it,
                                       output sohp_pkg::t_out_item res);
        longint u, y1, y2, y3, lin, y;
        logic signed [127:0] acc, t;
        logic [127:0] mag, p;
        logic [63:0] q;
        bit neg, over, sat;
        res = '0;
        if (it.kind == sohp_pkg::KIND_CLEAR) begin
            clear_history();
            return 1'b0;
        end
        u = longint'($signed(it.sample_in));
        y1 = hist_y[0];
        y2 = hist_y[1];
        y3 = hist_y[2];
        lin = u - hist_u[0] - hist_u[1] + hist_u[2] + y1 + y2 - y3;
        acc = lin;
        acc = acc <<< 26;
        t = y1 - y2 - y3;
        acc = acc - t * $signed({96'd0, coef_2aq});
        t = y3 + 3 * y2 + 3 * y1;
        acc = acc - t * $signed({96'd0, coef_asq});
        neg = acc[127];
        mag = neg ? -acc : acc;
        p = mag * {96'd0, inv_den};
        p = p + (128'd1 << 55);
        over = |p[127:120];
        q = p[119:56];
        sat = 1'b0;
        if (!neg) begin
            if (over || q > 64'(MaxPos)) begin
                y = MaxPos;
                sat = 1'b1;
            end else begin
                y = longint'(q);
            end
        end else begin
            if (over || q > 64'd8388608) begin
                y = -MaxPos - 1;
                sat = 1'b1;
            end else begin
                y = -longint'(q);
            end
        end
        hist_u[2] = hist_u[1];
        hist_u[1] = hist_u[0];
        hist_u[0] = u;
        hist_y[2] = y2;
        hist_y[1] = y1;
        hist_y[0] = y;
        res.sample_out = y[23:0];
        res.saturated = sat;
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string what, input logic [23:0] got,
                                   input logic [23:0] want);
        $display("MISMATCH %s: got %0h want %0h at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    // Send one item; valid stays high after acceptance unless a gap follows.
    task automatic send_item(input logic kind, input logic [23:0] smp);
        sohp_pkg::t_in_item it;
        sohp_pkg::t_out_item res;
        if (burst_left == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(20, 1)) @(posedge i_clk);
            burst_left = ($urandom_range(3, 0) == 0) ? 40 : $urandom_range(8, 1);
        end
        burst_left--;
        it.kind = kind;
        it.sample_in = smp;
        in_valid <= 1'b1;
        in_item <= it;
        do @(posedge i_clk); while (in_stall);
        if (filter_step(it, res)) expected_outputs.push_back(res);
    endtask

    task automatic send_sample(input logic [23:0] smp);
        send_item(sohp_pkg::KIND_SAMPLE, smp);
    endtask

    // Drain results and let the block go idle before touching registers.
    task automatic wait_idle();
        in_valid <= 1'b0;
        burst_left = 0;
        while (expected_outputs.size() != 0) @(posedge i_clk);
        repeat (IdleCycles) @(posedge i_clk);
    endtask

    task automatic write_reg(input sohp_pkg::t_cfg_idx idx, input logic [31:0] val);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= val;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        @(posedge i_clk);
        case (idx)
            sohp_pkg::CFG_CUTOFF: cutoff_reg = val;
            sohp_pkg::CFG_SHARP:  sharp_reg = val[23:0];
            sohp_pkg::CFG_PERIOD: period_reg = val;
            default:    return;
        endcase
        derive_coefs();
    endtask

    task automatic apply_setting(input logic [31:0] w, input logic [23:0] qf,
                                 input logic [31:0] ts);
        wait_idle();
        write_reg(sohp_pkg::CFG_CUTOFF, w);
        write_reg(sohp_pkg::CFG_SHARP, {8'd0, qf});
        write_reg(sohp_pkg::CFG_PERIOD, ts);
    endtask

    function automatic logic [23:0] rand_sample();
        case ($urandom_range(5, 0))
            0: return 24'h7FFFFF;
            1: return 24'h800000;
            2: return 24'($urandom_range(2000, 0)) - 24'd1000;
            default: return 24'($urandom);
        endcase
    endfunction

    task automatic test_directed_defaults();
        send_sample(24'h000000);
        send_sample(24'h7FFFFF);
        send_sample(24'h7FFFFF);
        send_sample(24'h800000);
        send_sample(24'h800000);
        send_sample(24'h7FFFFF);
        send_sample(24'h000001);
        send_sample(24'hFFFFFF);
        send_item(sohp_pkg::KIND_CLEAR, 24'h123456);
        send_sample(24'h400000);
        send_sample(24'h400000);
        send_item(sohp_pkg::KIND_CLEAR, 24'h000000);
        send_item(sohp_pkg::KIND_CLEAR, 24'hFFFFFF);
        send_sample(24'hC00000);
    endtask

    task automatic test_register_extremes();
        // huge a: both coefficients clip
        apply_setting(32'hFFFF_FFFF, 24'hFFFFFF, 32'hFFFF_FFFF);
        for (int i = 0; i < 6; i++) send_sample(rand_sample());
        // a rounds to zero
        apply_setting(32'd1, 24'd1, 32'd1);
        for (int i = 0; i < 6; i++) send_sample(rand_sample());
        // tiny Q makes 2a/Q clip
        apply_setting(32'd655360, 24'd1, 32'd4294967);
        for (int i = 0; i < 6; i++) send_sample(rand_sample());
        // unused index is ignored
        wait_idle();
        write_reg(sohp_pkg::CFG_NONE, 32'hDEAD_BEEF);
        for (int i = 0; i < 4; i++) send_sample(rand_sample());
    endtask

    task automatic test_random_phases();
        for (int ph = 0; ph < 8; ph++) begin
            if (ph % 2 == 0)
                apply_setting($urandom_range(32'h0400_0000, 32'h0001_0000),
                              24'($urandom_range(32'h0010_0000, 32'h0000_4000)),
                              $urandom_range(32'h0400_0000, 32'h0000_1000));
            else
                apply_setting($urandom, 24'($urandom_range(24'hFFFFFF, 1)), $urandom);
            for (int i = 0; i < 130; i++) begin
                if ($urandom_range(40, 0) == 0)
                    send_item(sohp_pkg::KIND_CLEAR, 24'($urandom));
                else send_sample(rand_sample());
            end
        end
    endtask

    initial begin
        for (int i = 0; i < 3; i++) begin
            hist_u[i] = 0;
            hist_y[i] = 0;
        end
        derive_coefs();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed_defaults();
        test_register_extremes();
        test_random_phases();
        wait_idle();
        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // Receiver stall pattern: free-running, random, bursty, or sparse stalls.
    int unsigned stall_mode = 0;
    int unsigned stall_cnt = 0;
    always @(posedge i_clk) begin
        stall_cnt <= stall_cnt + 1;
        if (stall_cnt % 300 == 0) stall_mode <= $urandom_range(3, 0);
        case (stall_mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(1, 0) == 1);
            2: out_stall <= (stall_cnt % 64) < 40;
            default: out_stall <= ($urandom_range(7, 0) == 0);
        endcase
    end

    always @(posedge i_clk) begin
        sohp_pkg::t_out_item want;
        if (out_valid && !out_stall) begin
            if (expected_outputs.size() == 0) begin
                report_mismatch("unexpected item", out_item.sample_out, 24'd0);
            end else begin
                want = expected_outputs.pop_front();
                if (out_item.sample_out !== want.sample_out)
                    report_mismatch("sample_out", out_item.sample_out, want.sample_out);
                if (out_item.saturated !== want.saturated)
                    report_mismatch("saturated", 24'(out_item.saturated),
                                    24'(want.saturated));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WatchLimit) begin
            $display("TIMEOUT at %0t", $realtime);
            $display("Verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule
